/* design/rcppm_pkg.sv */
// Package with the shared types and constants of the RC PPM/PWM pulse decoder.
`timescale 1ns / 1ps

package rcppm_pkg;

    localparam int TS_W  = 16;
    localparam int PORT_W = 3;
    localparam int CFG_IDX_W = 3;
    localparam int NUM_GOOD = 4;

    localparam logic [NUM_GOOD-1:0] GOOD_ALL = 4'hF;

    localparam logic [TS_W-1:0] RST_PULSE_MIN = 16'd750;
    localparam logic [TS_W-1:0] RST_PULSE_MAX = 16'd2250;
    localparam logic [TS_W-1:0] RST_SYNC_GAP  = 16'd2700;
    localparam logic [TS_W-1:0] RST_FAILSAFE  = 16'd985;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INPUT_MODE = 3'd0,
        CFG_PULSE_MIN  = 3'd1,
        CFG_PULSE_MAX  = 3'd2,
        CFG_SYNC_GAP   = 3'd3,
        CFG_FAILSAFE   = 3'd4
    } t_cfg_idx;

    typedef enum logic {
        MODE_PPM = 1'b0,
        MODE_PWM = 1'b1
    } t_mode;

    typedef enum logic {
        FUNC_CAPTURE = 1'b0,
        FUNC_READ    = 1'b1
    } t_func;

    typedef struct packed {
        logic              func;
        logic [PORT_W-1:0] port;
        logic [TS_W-1:0]   timestamp;
    } t_in_item;

    typedef struct packed {
        logic [TS_W-1:0]   read_width;
        logic              pulse_stored;
        logic [PORT_W-1:0] stored_channel;
        logic              valid_data;
        logic              arm_falling;
    } t_out_item;

endpackage

/* design/rcppm_in_if.sv */
// Handshake channel that carries capture and read requests into the decoder.
`timescale 1ns / 1ps

interface rcppm_in_if import rcppm_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

/* design/rcppm_out_if.sv */
// Handshake channel that carries decoder results.
`timescale 1ns / 1ps

interface rcppm_out_if import rcppm_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

/* design/rc_ppm_pwm_pulse_decoder.sv */
// RC PPM/PWM pulse decoder: width capture, channel table, good mask and result buffering.
// A result is registered in the output register, or in the skid entry while the output register is stalled.
// Items are taken at one item per cycle while the skid entry is empty; every item gives exactly one result.
// A two-entry output buffer lets one more item be taken while a result is stalled.
// Reset is synchronous: it clears the capture state, widths and valid flags and loads the register defaults.
// No clearing pass is needed; the decoder accepts items in the first cycle after reset.
`timescale 1ns / 1ps

module rc_ppm_pwm_pulse_decoder import rcppm_pkg::*; #(
    parameter int NUM_CHANNELS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [TS_W-1:0]      i_cfg_wdata,
    rcppm_in_if.sink             i_in,
    rcppm_out_if.source          o_out
);

    localparam int CH_W  = $clog2(NUM_CHANNELS);
    localparam int CNT_W = $clog2(NUM_CHANNELS + 1);
    localparam int PW    = (CNT_W > PORT_W) ? CNT_W : PORT_W;

    logic                  r_mode;
    logic [TS_W-1:0]       r_pulse_min;
    logic [TS_W-1:0]       r_pulse_max;
    logic [TS_W-1:0]       r_sync_gap;
    logic [TS_W-1:0]       r_failsafe;

    logic [TS_W-1:0]       r_ppm_last;
    logic [CNT_W-1:0]      r_ppm_ch;
    logic [NUM_CHANNELS-1:0] r_await;
    logic [TS_W-1:0]       r_rise  [NUM_CHANNELS];
    logic [TS_W-1:0]       r_width [NUM_CHANNELS];
    logic [NUM_GOOD-1:0]   r_good;

    t_out_item             r_out;
    logic                  r_out_vld;
    t_out_item             r_skid;
    logic                  r_skid_vld;

    logic                  in_fire;
    logic                  out_fire;
    logic [TS_W-1:0]       ts;
    logic [PW-1:0]         port_x;
    logic                  port_ok;
    logic                  ppm_ok;
    logic [TS_W-1:0]       gap;
    logic [TS_W-1:0]       pwm_w;

    logic                  upd_ppm;
    logic [CNT_W-1:0]      n_ppm_ch;
    logic                  rise_en;
    logic                  fall_en;
    logic                  store_en;
    logic [PW-1:0]         store_ch;
    logic [TS_W-1:0]       store_w;
    logic [NUM_GOOD-1:0]   mask_or;
    logic [NUM_GOOD-1:0]   n_good;
    t_out_item             res;

    assign in_fire  = i_in.valid & i_in.ready;
    assign out_fire = r_out_vld & o_out.ready;
    assign ts       = i_in.data.timestamp;
    assign port_x   = PW'(i_in.data.port);
    assign port_ok  = port_x < PW'(NUM_CHANNELS);
    assign ppm_ok   = r_ppm_ch < CNT_W'(NUM_CHANNELS);
    assign gap      = ts - r_ppm_last;
    assign pwm_w    = ts - r_rise[port_x[CH_W-1:0]];

    always_comb begin
        upd_ppm  = 1'b0;
        n_ppm_ch = r_ppm_ch;
        rise_en  = 1'b0;
        fall_en  = 1'b0;
        store_en = 1'b0;
        store_ch = '0;
        store_w  = '0;
        mask_or  = r_good;
        n_good   = r_good;
        res      = '0;

        if (i_in.data.func == FUNC_READ) begin
            if (port_ok) begin
                res.read_width = r_width[port_x[CH_W-1:0]];
            end
        end else if (r_mode == MODE_PPM) begin
            upd_ppm = 1'b1;
            if (gap > r_sync_gap) begin
                n_ppm_ch = '0;
            end else begin
                if (gap > r_pulse_min && gap < r_pulse_max && ppm_ok) begin
                    store_en = 1'b1;
                    store_ch = PW'(r_ppm_ch);
                    store_w  = gap;
                end
                if (ppm_ok) begin
                    n_ppm_ch = r_ppm_ch + CNT_W'(1);
                end
            end
        end else if (port_ok) begin
            if (!r_await[port_x[CH_W-1:0]]) begin
                rise_en = 1'b1;
                res.arm_falling = 1'b1;
            end else begin
                fall_en = 1'b1;
                if (pwm_w > r_pulse_min && pwm_w < r_pulse_max) begin
                    store_en = 1'b1;
                    store_ch = port_x;
                    store_w  = pwm_w;
                end
            end
        end

        if (store_en) begin
            if (store_ch < PW'(NUM_GOOD) && store_w > r_failsafe) begin
                mask_or = r_good | (NUM_GOOD'(1) << store_ch[1:0]);
            end
            if (mask_or == GOOD_ALL) begin
                n_good = '0;
                res.valid_data = 1'b1;
            end else begin
                n_good = mask_or;
            end
            res.pulse_stored   = 1'b1;
            res.stored_channel = store_ch[PORT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_PPM;
            r_pulse_min <= RST_PULSE_MIN;
            r_pulse_max <= RST_PULSE_MAX;
            r_sync_gap  <= RST_SYNC_GAP;
            r_failsafe  <= RST_FAILSAFE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_INPUT_MODE: r_mode      <= i_cfg_wdata[0];
                CFG_PULSE_MIN:  r_pulse_min <= i_cfg_wdata;
                CFG_PULSE_MAX:  r_pulse_max <= i_cfg_wdata;
                CFG_SYNC_GAP:   r_sync_gap  <= i_cfg_wdata;
                CFG_FAILSAFE:   r_failsafe  <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ppm_last <= '0;
            r_ppm_ch   <= '0;
            r_await    <= '0;
            r_good     <= '0;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_rise[i]  <= '0;
                r_width[i] <= '0;
            end
        end else if (in_fire) begin
            if (upd_ppm) begin
                r_ppm_last <= ts;
                r_ppm_ch   <= n_ppm_ch;
            end
            if (rise_en) begin
                r_rise[port_x[CH_W-1:0]]  <= ts;
                r_await[port_x[CH_W-1:0]] <= 1'b1;
            end
            if (fall_en) begin
                r_await[port_x[CH_W-1:0]] <= 1'b0;
            end
            if (store_en) begin
                r_width[store_ch[CH_W-1:0]] <= store_w;
            end
            r_good <= n_good;
        end
    end

    // The skid entry holds a result that arrived while the output register was stalled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (out_fire || !r_out_vld) begin
            if (r_skid_vld) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end else begin
                r_out_vld <= in_fire;
            end
        end else if (in_fire) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_fire || !r_out_vld) begin
            if (r_skid_vld) begin
                r_out <= r_skid;
            end else begin
                r_out <= res;
            end
        end else if (in_fire) begin
            r_skid <= res;
        end
    end

    assign i_in.ready  = !r_skid_vld;
    assign o_out.valid = r_out_vld;
    assign o_out.data  = r_out;

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("Skid entry is full while the output register is empty.");

    a_valid_needs_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.data.valid_data |-> o_out.data.pulse_stored)
        else $error("Valid-data pulse without a stored width.");

    a_read_no_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.data.read_width != '0
        |-> !o_out.data.pulse_stored && !o_out.data.arm_falling)
        else $error("Read result carries capture flags.");

    a_ppm_ch_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ppm_ch <= CNT_W'(NUM_CHANNELS))
        else $error("PPM channel counter ran past the channel count.");

    a_mask_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && res.valid_data |=> r_good == '0)
        else $error("Good mask did not clear after a valid-data pulse.");
`endif

endmodule

/* tb/pulse_decode_checker.sv */
// Checker that predicts the pulse decoder's results and compares every output transfer.
`timescale 1ns / 1ps

module pulse_decode_checker import rcppm_pkg::*; #(
    parameter int NUM_CHANNELS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [TS_W-1:0]      i_cfg_wdata,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  t_in_item             i_in_data,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  t_out_item            i_out_data,
    output int                   o_mismatches,
    output int                   o_outstanding
);

    t_mode                cur_mode;
    logic [TS_W-1:0]      win_lo;
    logic [TS_W-1:0]      win_hi;
    logic [TS_W-1:0]      sync_limit;
    logic [TS_W-1:0]      good_limit;

    logic [TS_W-1:0]      ppm_prev_edge;
    int unsigned          ppm_slot;
    logic                 falling_next [NUM_CHANNELS];
    logic [TS_W-1:0]      rise_at [NUM_CHANNELS];
    logic [TS_W-1:0]      width_of [NUM_CHANNELS];
    logic [NUM_GOOD-1:0]  good_bits;

    t_out_item            awaited_results [$];
    int                   mismatches;

    function automatic logic in_window(input logic [TS_W-1:0] w);
        return (w > win_lo) && (w < win_hi);
    endfunction

    // Stores a width and returns 1 when the last of channels 0 to 3 turns good.
    function automatic logic record_width(input int unsigned ch, input logic [TS_W-1:0] w);
        width_of[ch] = w;
        if (ch < NUM_GOOD && w > good_limit) begin
            good_bits[ch] = 1'b1;
        end
        if (good_bits == GOOD_ALL) begin
            good_bits = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic t_out_item decoded_result(input t_in_item it);
        t_out_item       r;
        logic [TS_W-1:0] w;
        int unsigned     p;
        r = '0;
        p = it.port;
        if (it.func == FUNC_READ) begin
            if (p < NUM_CHANNELS) begin
                r.read_width = width_of[p];
            end
        end else if (cur_mode == MODE_PPM) begin
            w = it.timestamp - ppm_prev_edge;
            ppm_prev_edge = it.timestamp;
            if (w > sync_limit) begin
                ppm_slot = 0;
            end else begin
                if (in_window(w) && ppm_slot < NUM_CHANNELS) begin
                    r.pulse_stored   = 1'b1;
                    r.stored_channel = ppm_slot[PORT_W-1:0];
                    r.valid_data     = record_width(ppm_slot, w);
                end
                if (ppm_slot < NUM_CHANNELS) begin
                    ppm_slot++;
                end
            end
        end else if (p < NUM_CHANNELS) begin
            if (!falling_next[p]) begin
                rise_at[p]      = it.timestamp;
                falling_next[p] = 1'b1;
            end else begin
                w = it.timestamp - rise_at[p];
                if (in_window(w)) begin
                    r.pulse_stored   = 1'b1;
                    r.stored_channel = it.port;
                    r.valid_data     = record_width(p, w);
                end
                falling_next[p] = 1'b0;
            end
            r.arm_falling = falling_next[p];
        end
        return r;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            cur_mode      = MODE_PPM;
            win_lo        = RST_PULSE_MIN;
            win_hi        = RST_PULSE_MAX;
            sync_limit    = RST_SYNC_GAP;
            good_limit    = RST_FAILSAFE;
            ppm_prev_edge = '0;
            ppm_slot      = 0;
            good_bits     = '0;
            for (int k = 0; k < NUM_CHANNELS; k++) begin
                falling_next[k] = 1'b0;
                rise_at[k]      = '0;
                width_of[k]     = '0;
            end
            awaited_results.delete();
            mismatches = 0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_INPUT_MODE: cur_mode   = t_mode'(i_cfg_wdata[0]);
                    CFG_PULSE_MIN:  win_lo     = i_cfg_wdata;
                    CFG_PULSE_MAX:  win_hi     = i_cfg_wdata;
                    CFG_SYNC_GAP:   sync_limit = i_cfg_wdata;
                    CFG_FAILSAFE:   good_limit = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (awaited_results.size() == 0) begin
                    $error("result transfer with no expected result waiting");
                    mismatches++;
                end else begin
                    want = awaited_results.pop_front();
                    check_field("read_width", want.read_width, i_out_data.read_width);
                    check_field("pulse_stored", want.pulse_stored, i_out_data.pulse_stored);
                    check_field("stored_channel", want.stored_channel,
                                i_out_data.stored_channel);
                    check_field("valid_data", want.valid_data, i_out_data.valid_data);
                    check_field("arm_falling", want.arm_falling, i_out_data.arm_falling);
                end
            end
            if (i_in_valid && i_in_ready) begin
                awaited_results.push_back(decoded_result(i_in_data));
            end
        end
        o_mismatches  <= mismatches;
        o_outstanding <= awaited_results.size();
    end

endmodule

/* tb/tb_rc_ppm_pwm_pulse_decoder.sv */
// Testbench top for the pulse decoder: clock, reset, register setup, capture stimulus and verdict.
`timescale 1ns / 1ps

module tb_rc_ppm_pwm_pulse_decoder;
    import rcppm_pkg::*;

    localparam int NUM_CH = 8;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [TS_W-1:0]      i_cfg_wdata;

    rcppm_in_if  in_ch ();
    rcppm_out_if out_ch ();

    int mismatches;
    int outstanding;

    int send_idle_pct;
    int recv_stall_pct;
    int hold_left;

    t_mode           cur_mode;
    logic [TS_W-1:0] cur_min;
    logic [TS_W-1:0] cur_max;
    logic [TS_W-1:0] cur_sync;

    logic [TS_W-1:0] ppm_gen_last;
    int unsigned     frame_left;
    logic [TS_W-1:0] pwm_rise [NUM_CH];
    logic            pwm_falling [NUM_CH];

    rc_ppm_pwm_pulse_decoder #(
        .NUM_CHANNELS(NUM_CH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    pulse_decode_checker #(
        .NUM_CHANNELS(NUM_CH)
    ) u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (in_ch.valid),
        .i_in_ready   (in_ch.ready),
        .i_in_data    (in_ch.data),
        .i_out_valid  (out_ch.valid),
        .i_out_ready  (out_ch.ready),
        .i_out_data   (out_ch.data),
        .o_mismatches (mismatches),
        .o_outstanding(outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

    // Result side: random stalls, plus long hold-offs requested by the stimulus.
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    function automatic t_in_item mk_item(input t_func f, input logic [PORT_W-1:0] p,
                                         input logic [TS_W-1:0] ts);
        t_in_item it;
        it.func      = f;
        it.port      = p;
        it.timestamp = ts;
        return it;
    endfunction

    function automatic logic [TS_W-1:0] window_width();
        int lo;
        int hi;
        lo = int'(cur_min) + 1;
        hi = int'(cur_max) - 1;
        if (hi < lo) begin
            return TS_W'($urandom);
        end
        case ($urandom_range(7))
            0: return TS_W'(lo);
            1: return TS_W'(hi);
            default: return TS_W'($urandom_range(hi, lo));
        endcase
    endfunction

    // Mostly well-formed frames and edge pairs, with some reads and random edges.
    function automatic t_in_item next_item();
        t_in_item    it;
        int unsigned roll;
        int unsigned lo;
        int unsigned hi;
        int unsigned p;
        it   = mk_item(FUNC_CAPTURE, PORT_W'($urandom_range(7)), TS_W'($urandom));
        roll = $urandom_range(99);
        if (roll < 10) begin
            it.func = FUNC_READ;
        end else if (roll >= 22 && cur_mode == MODE_PPM) begin
            if (frame_left == 0) begin
                if (cur_sync != 16'hFFFF) begin
                    lo = int'(cur_sync) + 1;
                    hi = (lo + 2000 > 65535) ? 65535 : lo + 2000;
                    it.timestamp = ppm_gen_last + TS_W'($urandom_range(hi, lo));
                end
                frame_left = $urandom_range(10, 1);
            end else begin
                it.timestamp = ppm_gen_last + window_width();
                frame_left--;
            end
        end else if (roll >= 22) begin
            p = it.port;
            if (pwm_falling[p]) begin
                it.timestamp = pwm_rise[p] + window_width();
            end
        end
        return it;
    endfunction

    task automatic send_item(input t_in_item it);
        int unsigned p;
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        do @(posedge i_clk); while (!in_ch.ready);
        if (it.func == FUNC_CAPTURE) begin
            if (cur_mode == MODE_PPM) begin
                ppm_gen_last = it.timestamp;
            end else begin
                p = it.port;
                if (!pwm_falling[p]) begin
                    pwm_rise[p] = it.timestamp;
                end
                pwm_falling[p] = !pwm_falling[p];
            end
        end
    endtask

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apply_settings(input t_mode m, input logic [TS_W-1:0] lo,
                                  input logic [TS_W-1:0] hi, input logic [TS_W-1:0] sync,
                                  input logic [TS_W-1:0] fs);
        t_cfg_idx        regs [5];
        logic [TS_W-1:0] vals [5];
        int              k;
        regs = '{CFG_INPUT_MODE, CFG_PULSE_MIN, CFG_PULSE_MAX, CFG_SYNC_GAP, CFG_FAILSAFE};
        vals = '{{{(TS_W-1){1'b0}}, m}, lo, hi, sync, fs};
        i_cfg_we <= 1'b1;
        for (k = 0; k < 5; k++) begin
            i_cfg_idx   <= regs[k];
            i_cfg_wdata <= vals[k];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        cur_mode = m;
        cur_min  = lo;
        cur_max  = hi;
        cur_sync = sync;
    endtask

    initial begin
        int              ppm_gaps [12];
        logic [TS_W-1:0] t;
        t_mode           m;
        int              ph;
        int              n;

        ppm_gaps = '{65000, 1500, 1200, 2249, 986, 750, 2250, 2700, 985, 1000, 1000, 2701};
        in_ch.valid   <= 1'b0;
        in_ch.data    <= '0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= CFG_INPUT_MODE;
        i_cfg_wdata   <= '0;
        i_rst_n       <= 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = 0;
        cur_mode       = MODE_PPM;
        cur_min        = RST_PULSE_MIN;
        cur_max        = RST_PULSE_MAX;
        cur_sync       = RST_SYNC_GAP;
        ppm_gen_last   = '0;
        frame_left     = 0;
        for (n = 0; n < NUM_CH; n++) begin
            pwm_rise[n]    = '0;
            pwm_falling[n] = 1'b0;
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reads before any capture, then one PPM frame that wraps the timer, hits the
        // window and sync bounds exactly, completes the good mask and overruns the table.
        send_item(mk_item(FUNC_READ, 0, TS_W'($urandom)));
        send_item(mk_item(FUNC_READ, 7, TS_W'($urandom)));
        t = '0;
        for (n = 0; n < 12; n++) begin
            t = t + TS_W'(ppm_gaps[n]);
            send_item(mk_item(FUNC_CAPTURE, PORT_W'($urandom_range(7)), t));
        end
        send_item(mk_item(FUNC_READ, 0, TS_W'($urandom)));
        send_item(mk_item(FUNC_READ, 7, TS_W'($urandom)));

        // PWM edge pairs: a wrapped width, a zero width, a full-range width and one
        // just under the upper bound.
        wait_idle();
        apply_settings(MODE_PWM, RST_PULSE_MIN, RST_PULSE_MAX, RST_SYNC_GAP, RST_FAILSAFE);
        send_item(mk_item(FUNC_CAPTURE, 3, 16'd65500));
        send_item(mk_item(FUNC_READ, 3, 16'd0));
        send_item(mk_item(FUNC_CAPTURE, 3, 16'd1000));
        send_item(mk_item(FUNC_CAPTURE, 5, 16'd100));
        send_item(mk_item(FUNC_CAPTURE, 5, 16'd100));
        send_item(mk_item(FUNC_CAPTURE, 0, 16'd0));
        send_item(mk_item(FUNC_CAPTURE, 0, 16'd65535));
        send_item(mk_item(FUNC_CAPTURE, 7, 16'd40000));
        send_item(mk_item(FUNC_CAPTURE, 7, 16'd42249));

        for (ph = 0; ph < 12; ph++) begin
            wait_idle();
            m = ((ph + ph / 4) % 2 != 0) ? MODE_PWM : MODE_PPM;
            case (ph / 4)
                0: apply_settings(m, RST_PULSE_MIN, RST_PULSE_MAX, RST_SYNC_GAP,
                                  RST_FAILSAFE);
                1: apply_settings(m, TS_W'($urandom_range(1000, 500)),
                                  TS_W'($urandom_range(2500, 1800)),
                                  TS_W'($urandom_range(4000, 2400)),
                                  TS_W'($urandom_range(1600, 800)));
                default: begin
                    if (ph % 2 == 0) begin
                        apply_settings(m, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0);
                    end else begin
                        apply_settings(m, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF);
                    end
                end
            endcase
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
                default: begin send_idle_pct = 25; recv_stall_pct = 25; end
            endcase
            for (n = 0; n < 150; n++) begin
                if (ph == 0 && n == 40) begin
                    hold_left = 300;
                end
                if (ph == 2 && n == 75) begin
                    wait_idle();
                end
                send_item(next_item());
            end
        end

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

/* rc_ppm_pwm_pulse_decoder.f */
design/rcppm_pkg.sv
design/rcppm_in_if.sv
design/rcppm_out_if.sv
design/rc_ppm_pwm_pulse_decoder.sv
tb/pulse_decode_checker.sv
tb/tb_rc_ppm_pwm_pulse_decoder.sv
